>>> src/cesu8_stream_validator_macros.svh
// Assertion macros for the CESU-8 stream validator.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef CESU8_STREAM_VALIDATOR_MACROS_SVH
`define CESU8_STREAM_VALIDATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CESU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");
`define CESU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define CESU_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CESU_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> src/cesu_pkg.sv
// Shared types, defaults and nibble lookup tables of the CESU-8 validator.
// No dependencies.
`timescale 1ns / 1ps
package cesu_pkg;
	localparam int unsigned LANES_DEF = 8;
	localparam int unsigned DATA_W    = 64;

	typedef struct packed {
		logic hi;   // partial mask bit 7: high surrogate mark
		logic lo;   // partial mask bit 6: low surrogate expected
		logic seq;  // sequence error for this byte
		logic hdr;  // illegal header nibble
	} lane_flags_t;

	typedef struct packed {
		logic valid;
		logic last;
	} s1_ctrl_t;

	function automatic logic [7:0] tab_cur(input logic [3:0] n);
		logic [7:0] v;
		case (n) inside
			4'h8, 4'h9, 4'hA, 4'hB: v = 8'h3C;
			4'hF:                   v = 8'h00;
			default:                v = 8'h33;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] tab_prev(input logic [3:0] n);
		logic [7:0] v;
		case (n) inside
			4'h8, 4'h9:       v = 8'h3A;
			4'hA:             v = 8'h9A;
			4'hB:             v = 8'h5A;
			4'hC, 4'hD, 4'hE: v = 8'h11;
			4'hF:             v = 8'h00;
			default:          v = 8'h14;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] tab_old_hi(input logic [3:0] n);
		logic [7:0] v;
		case (n) inside
			4'h8, 4'h9, 4'hA, 4'hB, 4'hD: v = 8'h0D;
			4'hC:                         v = 8'h1D;
			4'hE:                         v = 8'hE7;
			4'hF:                         v = 8'h00;
			default:                      v = 8'h05;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] tab_old_lo(input logic [3:0] n);
		logic [7:0] v;
		case (n)
			4'h0:    v = 8'h3F;
			4'h1:    v = 8'h1F;
			4'hD:    v = 8'hCF;
			default: v = 8'h0F;
		endcase
		return v;
	endfunction
endpackage

>>> src/cesu_ifs.sv
// Valid/ready channel interfaces: stream requests in, verdict requests out.
// Depends on nothing.
`timescale 1ns / 1ps
interface cesu_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_bytes;
	logic [3:0]  valid_bytes;
	logic        last;
	modport source (output valid, data_bytes, valid_bytes, last, input ready);
	modport sink   (input valid, data_bytes, valid_bytes, last, output ready);
endinterface

interface cesu_out_if;
	logic valid;
	logic ready;
	logic stream_valid;
	logic sequence_error;
	logic surrogate_error;
	logic header_error;
	modport source (output valid, stream_valid, sequence_error, surrogate_error,
		header_error, input ready);
	modport sink   (input valid, stream_valid, sequence_error, surrogate_error,
		header_error, output ready);
endinterface

>>> src/cesu_lane.sv
// One byte lane: window lookup over the byte and the two bytes before it.
// Depends on cesu_pkg.
`timescale 1ns / 1ps
module cesu_lane
	import cesu_pkg::*;
(
	input  logic [7:0]  cur,
	input  logic [7:0]  p1,
	input  logic [7:0]  p2,
	output lane_flags_t flags
);
	logic [7:0] part;

	assign part = tab_prev(p1[7:4]) & tab_old_hi(p2[7:4]) & tab_old_lo(p2[3:0]);

	assign flags.hi  = part[7];
	assign flags.lo  = part[6];
	assign flags.seq = |(part & tab_cur(cur[7:4]));
	assign flags.hdr = (cur[7:4] == 4'hF);
endmodule

>>> src/cesu_merge.sv
// Merge stage: OR lane errors into sticky flags and hold the verdict register.
// Depends on cesu_pkg and cesu_ifs.
`timescale 1ns / 1ps
module cesu_merge
	import cesu_pkg::*;
#(
	parameter int unsigned NP = LANES_DEF + 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  s1_ctrl_t          ctrl,
	input  logic [NP-1:0]     seq_err,
	input  logic [NP-1:0]     sur_err,
	input  logic [NP-1:0]     hdr_err,
	output logic              adv,
	cesu_out_if.source        result
);
	logic       valid_q;
	logic [2:0] sticky_q;
	logic [2:0] flags_q;
	logic [2:0] merged;

	// bit 0 sequence, bit 1 surrogate, bit 2 header
	assign merged = sticky_q | {|hdr_err, |sur_err, |seq_err};
	assign adv    = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			sticky_q <= '0;
		end else if (adv) begin
			valid_q <= ctrl.valid && ctrl.last;
			if (ctrl.valid) begin
				sticky_q <= ctrl.last ? 3'b000 : merged;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctrl.valid && ctrl.last) begin
			flags_q <= merged;
		end
	end

	assign result.valid           = valid_q;
	assign result.stream_valid    = (flags_q == 3'b000);
	assign result.sequence_error  = flags_q[0];
	assign result.surrogate_error = flags_q[1];
	assign result.header_error    = flags_q[2];
endmodule

>>> src/cesu8_stream_validator.sv
// CESU-8 stream validator top level: LANES + 3 byte lanes, lane error register, merge.
// Throughput: one request per cycle while the verdict register is not stalled. A last
// request's verdict passes the lane error register, then the verdict register; a stall
// holds both. The window state update keeps two bytes and three marks.
// Reset (arst_n low, asynchronous) clears window state, sticky flags and valids.
`timescale 1ns / 1ps
`include "cesu8_stream_validator_macros.svh"
module cesu8_stream_validator
	import cesu_pkg::*;
#(
	parameter int unsigned LANES = LANES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	cesu_in_if.sink    stream,
	cesu_out_if.source result
);
	// Positions: LANES data bytes followed by three flush bytes on a last request.
	localparam int unsigned NP = LANES + 3;
	localparam int unsigned NW = $clog2(LANES + 4);
	localparam int unsigned CW = (NW > 4) ? NW : 4;

	logic          adv;
	logic          accept;
	logic [CW-1:0] vb_ext;
	logic [CW-1:0] cnt_c;
	logic [NW-1:0] cnt_n;

	// Window state: previous bytes and high-surrogate marks.
	logic [7:0] prev_q  [2];
	logic       marks_q [3];

	logic [7:0]  pos_byte [NP];
	lane_flags_t flags    [NP];
	logic [NP-1:0] active;
	logic [NP-1:0] seq_c, sur_c, hdr_c;

	logic [7:0] ext_byte [LANES + 2];
	logic       ext_mark [LANES + 3];
	logic [7:0] nxt_prev0, nxt_prev1;
	logic       nxt_mark0, nxt_mark1, nxt_mark2;

	s1_ctrl_t      ctrl_s1;
	logic [NP-1:0] seq_s1, sur_s1, hdr_s1;

	logic verdict_err;
	logic win_zero;

	assign stream.ready = adv;
	assign accept       = stream.valid && adv;

	// Clamp the byte count to the lane count.
	assign vb_ext = CW'(stream.valid_bytes);
	assign cnt_c  = (vb_ext > CW'(LANES)) ? CW'(LANES) : vb_ext;
	assign cnt_n  = NW'(cnt_c);

	genvar j;
	generate
		for (j = 0; j < NP; j++) begin : g_lane
			logic [7:0] p1, p2;
			logic       mark;

			// Bytes past the count, and flush positions, read as zero.
			if (j < 8 && j < LANES) begin : g_data
				assign pos_byte[j] = (NW'(j) < cnt_n) ? stream.data_bytes[8*j +: 8] : 8'h00;
			end else begin : g_zero
				assign pos_byte[j] = 8'h00;
			end

			if (j == 0) begin : g_w0
				assign p1 = prev_q[0];
				assign p2 = prev_q[1];
			end else if (j == 1) begin : g_w1
				assign p1 = pos_byte[0];
				assign p2 = prev_q[0];
			end else begin : g_wn
				assign p1 = pos_byte[j-1];
				assign p2 = pos_byte[j-2];
			end

			// Mark from three positions back; early lanes take it from state.
			if (j >= 3) begin : g_mk
				assign mark = flags[j-3].hi;
			end else begin : g_ms
				assign mark = marks_q[2-j];
			end

			cesu_lane u_lane (
				.cur   (pos_byte[j]),
				.p1    (p1),
				.p2    (p2),
				.flags (flags[j])
			);

			assign active[j] = (NW'(j) < cnt_n) ||
				(stream.last && (NW'(j) < (cnt_n + NW'(3))));
			assign seq_c[j] = active[j] && flags[j].seq;
			assign sur_c[j] = active[j] && (mark != flags[j].lo);
			assign hdr_c[j] = active[j] && flags[j].hdr;
		end

		// State-prefixed views used to pick the window left behind by this request.
		for (j = 0; j < LANES + 2; j++) begin : g_eb
			if (j == 0) begin : g_b0
				assign ext_byte[j] = prev_q[1];
			end else if (j == 1) begin : g_b1
				assign ext_byte[j] = prev_q[0];
			end else begin : g_bn
				assign ext_byte[j] = pos_byte[j-2];
			end
		end
		for (j = 0; j < LANES + 3; j++) begin : g_em
			if (j < 3) begin : g_ms
				assign ext_mark[j] = marks_q[2-j];
			end else begin : g_mn
				assign ext_mark[j] = flags[j-3].hi;
			end
		end
	endgenerate

	// Select the state after the last counted byte.
	always_comb begin
		nxt_prev0 = prev_q[0];
		nxt_prev1 = prev_q[1];
		nxt_mark0 = marks_q[0];
		nxt_mark1 = marks_q[1];
		nxt_mark2 = marks_q[2];
		for (int k = 0; k <= LANES; k++) begin
			if (cnt_n == NW'(k)) begin
				nxt_prev0 = ext_byte[k+1];
				nxt_prev1 = ext_byte[k];
				nxt_mark0 = ext_mark[k+2];
				nxt_mark1 = ext_mark[k+1];
				nxt_mark2 = ext_mark[k];
			end
		end
	end

	// Advance window state on each accepted request; drop it after a last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q[0]  <= '0;
			prev_q[1]  <= '0;
			marks_q[0] <= 1'b0;
			marks_q[1] <= 1'b0;
			marks_q[2] <= 1'b0;
		end else if (accept) begin
			if (stream.last) begin
				prev_q[0]  <= '0;
				prev_q[1]  <= '0;
				marks_q[0] <= 1'b0;
				marks_q[1] <= 1'b0;
				marks_q[2] <= 1'b0;
			end else begin
				prev_q[0]  <= nxt_prev0;
				prev_q[1]  <= nxt_prev1;
				marks_q[0] <= nxt_mark0;
				marks_q[1] <= nxt_mark1;
				marks_q[2] <= nxt_mark2;
			end
		end
	end

	// Lane error register; hold while the verdict register is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (adv) begin
			ctrl_s1.valid <= stream.valid;
			ctrl_s1.last  <= stream.last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			seq_s1 <= seq_c;
			sur_s1 <= sur_c;
			hdr_s1 <= hdr_c;
		end
	end

	cesu_merge #(
		.NP (NP)
	) u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl_s1),
		.seq_err (seq_s1),
		.sur_err (sur_s1),
		.hdr_err (hdr_s1),
		.adv     (adv),
		.result  (result)
	);

	assign verdict_err = result.sequence_error || result.surrogate_error ||
		result.header_error;
	assign win_zero = (prev_q[0] == 8'h00) && (prev_q[1] == 8'h00) &&
		!marks_q[0] && !marks_q[1] && !marks_q[2];

	// A verdict reports the stream valid exactly when no error class is set.
	`CESU_ASSERT_IMP(a_verdict, clk, arst_n, result.valid, result.stream_valid == !verdict_err)
	// Window state is cleared after a last request.
	`CESU_ASSERT_NXT(a_clear, clk, arst_n, accept && stream.last, win_zero)
	// A last request in the lane stage lands in the verdict register.
	`CESU_ASSERT_NXT(a_result, clk, arst_n, adv && ctrl_s1.valid && ctrl_s1.last, result.valid)
endmodule

>>> tb/cesu8_stream_validator_tb.sv
// Self-checking testbench of cesu8_stream_validator: byte-window verdict prediction,
// directed and random CESU-8 streams, random idling on both channels.
// Depends on cesu_pkg, cesu_in_if / cesu_out_if and the validator RTL.
`timescale 1ns / 1ps
module cesu8_stream_validator_tb
	import cesu_pkg::*;
();

	localparam int unsigned LANES        = LANES_DEF;
	localparam int          STREAM_ITEMS = 1300;   // random part stops here
	localparam int          QUIET_ITEMS  = 150;    // tail of the run without idling
	localparam int          HOLD_CYCLES  = 300;    // long receiver hold-off
	localparam int          HOLD_ITEMS   = 40;     // one-item streams pushed during it
	localparam int          SETTLE_EDGES = 8;      // settle time after the drain
	localparam int          CYCLE_LIMIT  = 200000;

	// Error flag positions in the sticky register.
	localparam int SEQ_BIT = 0;
	localparam int SUR_BIT = 1;
	localparam int HDR_BIT = 2;

	// Nibble masks, indexed by nibble value.
	localparam logic [7:0] CUR_MASK [16] = '{
		8'h33, 8'h33, 8'h33, 8'h33, 8'h33, 8'h33, 8'h33, 8'h33,
		8'h3C, 8'h3C, 8'h3C, 8'h3C, 8'h33, 8'h33, 8'h33, 8'h00};
	localparam logic [7:0] PREV_MASK [16] = '{
		8'h14, 8'h14, 8'h14, 8'h14, 8'h14, 8'h14, 8'h14, 8'h14,
		8'h3A, 8'h3A, 8'h9A, 8'h5A, 8'h11, 8'h11, 8'h11, 8'h00};
	localparam logic [7:0] OLD_HI_MASK [16] = '{
		8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05,
		8'h0D, 8'h0D, 8'h0D, 8'h0D, 8'h1D, 8'h0D, 8'hE7, 8'h00};
	localparam logic [7:0] OLD_LO_MASK [16] = '{
		8'h3F, 8'h1F, 8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'h0F,
		8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'hCF, 8'h0F, 8'h0F};

	typedef struct packed {
		logic stream_valid;
		logic sequence_error;
		logic surrogate_error;
		logic header_error;
	} verdict_t;

	// Tracks the byte window of the stream under way and the verdicts still owed.
	class verdict_ledger;
		logic [7:0] window_bytes [2];   // [0] newest
		logic [2:0] surrogate_marks;    // [0] newest
		logic [2:0] sticky_flags;
		verdict_t   owed_verdicts [$];
		int         fails;

		function new();
			clear_window();
			fails = 0;
		endfunction

		function void clear_window();
			window_bytes[0] = 8'h00;
			window_bytes[1] = 8'h00;
			surrogate_marks = 3'b000;
			sticky_flags    = 3'b000;
		endfunction

		function void judge_byte(logic [7:0] b);
			logic [7:0] part;
			part = PREV_MASK[window_bytes[0][7:4]] & OLD_HI_MASK[window_bytes[1][7:4]]
				& OLD_LO_MASK[window_bytes[1][3:0]];
			if ((part & CUR_MASK[b[7:4]]) != 8'h00)
				sticky_flags[SEQ_BIT] = 1'b1;
			if (surrogate_marks[2] != part[6])
				sticky_flags[SUR_BIT] = 1'b1;
			if (b[7:4] == 4'hF)
				sticky_flags[HDR_BIT] = 1'b1;
			surrogate_marks = {surrogate_marks[1:0], part[7]};
			window_bytes[1] = window_bytes[0];
			window_bytes[0] = b;
		endfunction

		function void note_request(logic [63:0] data, logic [3:0] count, logic last);
			int       n;
			verdict_t v;
			n = (count > LANES) ? LANES : count;
			for (int i = 0; i < n; i++)
				judge_byte((i < 8) ? data[i*8 +: 8] : 8'h00);
			if (last) begin
				// Flush: three zero bytes expose unfinished sequences and pairs.
				repeat (3) judge_byte(8'h00);
				v.stream_valid    = (sticky_flags == 3'b000);
				v.sequence_error  = sticky_flags[SEQ_BIT];
				v.surrogate_error = sticky_flags[SUR_BIT];
				v.header_error    = sticky_flags[HDR_BIT];
				owed_verdicts.push_back(v);
				clear_window();
			end
		endfunction

		function void compare_bit(string field, logic want, logic got);
			if (want !== got) begin
				$error("%s: expected %0b, actual %0b", field, want, got);
				fails++;
			end
		endfunction

		function void check_verdict(verdict_t got);
			verdict_t want;
			if (owed_verdicts.size() == 0) begin
				$error("verdict with none owed: stream_valid %0b seq %0b sur %0b hdr %0b",
					got.stream_valid, got.sequence_error, got.surrogate_error,
					got.header_error);
				fails++;
				return;
			end
			want = owed_verdicts.pop_front();
			compare_bit("stream_valid", want.stream_valid, got.stream_valid);
			compare_bit("sequence_error", want.sequence_error, got.sequence_error);
			compare_bit("surrogate_error", want.surrogate_error, got.surrogate_error);
			compare_bit("header_error", want.header_error, got.header_error);
		endfunction

		function int owed();
			return owed_verdicts.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	cesu_in_if  stream_ch ();
	cesu_out_if result_ch ();

	cesu8_stream_validator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_ch),
		.result (result_ch)
	);

	verdict_ledger ledger;
	logic [7:0]    stream_bytes [$];    // bytes of the stream being built
	int            items_sent  = 0;
	int            gap_pct     = 0;     // sender idling, re-drawn per stream
	bit            quiet       = 1'b0;  // no idling on either side
	int            hold_asks   = 0;     // bumped by the sender to ask for a hold-off
	int            cycle_count = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog: abort a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Receiver: check every accepted verdict, then pick ready for the next edge.
	// Stalls come in bursts; a hold-off asked by the sender overrides them.
	int hold_seen  = 0;
	int stall_left = 0;
	int stall_pct  = 0;
	int stall_tick = 0;
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			ledger.check_verdict('{result_ch.stream_valid, result_ch.sequence_error,
				result_ch.surrogate_error, result_ch.header_error});
		stall_tick++;
		if (stall_tick % 64 == 0)
			stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
		if (hold_seen != hold_asks) begin
			hold_seen  = hold_asks;
			stall_left = HOLD_CYCLES;
		end
		if (stall_left > 0) begin
			result_ch.ready <= 1'b0;
			stall_left--;
		end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
			result_ch.ready <= 1'b0;
			stall_left = $urandom_range(1, 13) - 1;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	// Offer one request and hold it until the block takes it. Leave valid high
	// unless a gap follows, so back-to-back requests see no bubble.
	task automatic send_request(logic [63:0] data, logic [3:0] count, logic last);
		stream_ch.valid       <= 1'b1;
		stream_ch.data_bytes  <= data;
		stream_ch.valid_bytes <= count;
		stream_ch.last        <= last;
		do @(posedge clk); while (!stream_ch.ready);
		ledger.note_request(data, count, last);
		items_sent++;
		if (!quiet && $urandom_range(0, 99) < gap_pct) begin
			stream_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	// Drop valid and hold until every owed verdict has come back.
	task automatic drain_verdicts();
		stream_ch.valid <= 1'b0;
		while (ledger.owed() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] cont_byte();
		return 8'h80 | 8'($urandom_range(0, 63));
	endfunction

	// Append one well-formed character: ASCII, two-byte, three-byte or a
	// surrogate pair.
	function automatic void push_char();
		logic [7:0] lead;
		case ($urandom_range(0, 5))
			0, 1: stream_bytes.push_back(8'($urandom_range(0, 127)));
			2: begin
				stream_bytes.push_back(8'($urandom_range(8'hC2, 8'hDF)));
				stream_bytes.push_back(cont_byte());
			end
			3, 4: begin
				lead = 8'($urandom_range(8'hE0, 8'hEF));
				stream_bytes.push_back(lead);
				if (lead == 8'hE0)
					stream_bytes.push_back(8'($urandom_range(8'hA0, 8'hBF)));
				else if (lead == 8'hED)
					stream_bytes.push_back(8'($urandom_range(8'h80, 8'h9F)));
				else
					stream_bytes.push_back(cont_byte());
				stream_bytes.push_back(cont_byte());
			end
			default: begin
				stream_bytes.push_back(8'hED);
				stream_bytes.push_back(8'($urandom_range(8'hA0, 8'hAF)));
				stream_bytes.push_back(cont_byte());
				stream_bytes.push_back(8'hED);
				stream_bytes.push_back(8'($urandom_range(8'hB0, 8'hBF)));
				stream_bytes.push_back(cont_byte());
			end
		endcase
	endfunction

	// Build a stream: mostly well-formed, some broken by one bad or missing
	// byte, some pure noise.
	function automatic void build_stream();
		int chars;
		int kind;
		int pos;
		stream_bytes.delete();
		chars = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 8);
		kind  = $urandom_range(0, 9);
		if (kind == 0) begin
			repeat (chars + 1) stream_bytes.push_back(8'($urandom));
		end else begin
			repeat (chars) push_char();
			if (kind == 1 && stream_bytes.size() > 0) begin
				pos = $urandom_range(0, stream_bytes.size() - 1);
				stream_bytes[pos] = 8'($urandom);
			end else if (kind == 2 && stream_bytes.size() > 0) begin
				void'(stream_bytes.pop_back());
			end
		end
	endfunction

	// Place take stream bytes from pos in the low lanes; fill the rest with junk.
	function automatic logic [63:0] pack_lanes(int pos, int take);
		logic [63:0] data;
		data = {$urandom, $urandom};
		for (int i = 0; i < take; i++)
			data[i*8 +: 8] = stream_bytes[pos + i];
		return data;
	endfunction

	// Cut the built stream into requests: mostly full words, some short or
	// empty ones, counts above eight now and then, then the last request.
	task automatic send_stream();
		int         pos;
		int         rem;
		int         take;
		int         pick;
		logic [3:0] count;
		pos = 0;
		forever begin
			rem = stream_bytes.size() - pos;
			if (rem <= 8 && (rem == 0 || $urandom_range(0, 3) != 0)) begin
				count = 4'(rem);
				if (rem == 8 && $urandom_range(0, 3) == 0)
					count = 4'($urandom_range(9, 15));
				send_request(pack_lanes(pos, rem), count, 1'b1);
				break;
			end
			pick = $urandom_range(0, 9);
			if (pick == 0)
				take = 0;
			else if (pick <= 2)
				take = $urandom_range(1, (rem < 7) ? rem : 7);
			else
				take = (rem < 8) ? rem : 8;
			count = 4'(take);
			if (take == 8 && pick == 3)
				count = 4'($urandom_range(9, 15));
			send_request(pack_lanes(pos, take), count, 1'b0);
			pos += take;
		end
	endtask

	task automatic run_directed();
		send_request(64'h0, 4'd0, 1'b1);                      // empty stream
		send_request(64'h4847_4645_4443_4241, 4'd8, 1'b1);    // plain ASCII
		send_request(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);    // all ones, bad headers
		send_request(64'h0, 4'd15, 1'b1);                     // count above lanes
		send_request(64'h0000_80B0_ED80_A0ED, 4'd6, 1'b1);    // surrogate pair
		send_request(64'h0000_0000_4180_A0ED, 4'd4, 1'b1);    // lone high surrogate
		send_request(64'h0000_0000_0080_B0ED, 4'd3, 1'b1);    // lone low surrogate
		send_request(64'h0000_0000_0000_80C0, 4'd2, 1'b1);    // overlong two-byte
		send_request(64'h0000_0000_0080_80E0, 4'd3, 1'b1);    // overlong three-byte
		send_request(64'h0000_0000_0000_00C3, 4'd1, 1'b1);    // cut short by the flush
		send_request(64'h0000_0000_0000_0080, 4'd1, 1'b1);    // stray continuation
		send_request(64'h0000_0000_8080_90F0, 4'd4, 1'b1);    // four-byte header
		send_request(64'h0000_00A9_C3AD_B8E4, 4'd5, 1'b1);    // valid three- and two-byte
		// Short requests mid-stream with junk in the ignored lanes and an empty one
		// between them, then a last request whose count exceeds the lanes.
		send_request(64'hFFFF_FFFF_FF80_A0ED, 4'd3, 1'b0);
		send_request(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0);
		send_request(64'hAAAA_AAAA_AA80_B0ED, 4'd3, 1'b0);
		send_request(64'h4847_4645_4443_4241, 4'd9, 1'b1);
		// Surrogate pair split across a word boundary.
		send_request(64'hA0ED_4141_4141_4141, 4'd8, 1'b0);
		send_request(64'h0000_0000_80B0_ED80, 4'd4, 1'b1);
	endtask

	initial begin
		ledger = new();
		stream_ch.valid       <= 1'b0;
		stream_ch.data_bytes  <= 64'h0;
		stream_ch.valid_bytes <= 4'd0;
		stream_ch.last        <= 1'b0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct = 20;
		run_directed();
		// Pause the sender until the pipeline has emptied.
		drain_verdicts();
		@(posedge clk);

		while (items_sent < STREAM_ITEMS) begin
			if (hold_asks == 0 && items_sent > STREAM_ITEMS / 2) begin
				// Hold off the receiver and keep pushing one-request streams so
				// the block backs up and stalls its input.
				hold_asks++;
				gap_pct = 0;
				repeat (HOLD_ITEMS)
					send_request({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b1);
			end
			if (items_sent > STREAM_ITEMS - QUIET_ITEMS)
				quiet = 1'b1;
			case ($urandom_range(0, 2))
				0:       gap_pct = 0;
				1:       gap_pct = 10;
				default: gap_pct = 35;
			endcase
			build_stream();
			send_stream();
		end

		drain_verdicts();
		repeat (SETTLE_EDGES) @(posedge clk);
		if (ledger.fails == 0 && ledger.owed() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

>>> sim.f
+incdir+src
src/cesu_pkg.sv
src/cesu_ifs.sv
src/cesu_lane.sv
src/cesu_merge.sv
src/cesu8_stream_validator.sv
tb/cesu8_stream_validator_tb.sv
